/* rtl/gms_pkg.sv */
package gms_pkg;

  // Payload of one task transfer.
  typedef struct packed {
    logic [15:0] task_work;
    logic        last_task;
  } gms_in_t;

  // Payload of one result transfer.
  typedef struct packed {
    logic [3:0]  chosen_proc;
    logic [31:0] makespan;
    logic        job_done;
  } gms_out_t;

  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned WorkW    = 16;
  localparam int unsigned SpanW    = 32;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegNumProcs   = 8'd0;
  localparam logic [CfgIdxW-1:0] RegPolicyMode = 8'd1;

  localparam logic PolicyLeast = 1'b0;
  localparam logic PolicyBest  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } gms_state_e;

  // Control from the sequencer to the compare unit.
  typedef struct packed {
    logic clear;  // start of a new task: drop the previous candidates
    logic take;   // a load word is on the read port this cycle
    logic fin;    // final step: the adder works on the least load
  } gms_scan_ctl_t;

endpackage

/* rtl/gms_load_ram.sv */
module gms_load_ram #(
  parameter int unsigned PROCS     = 16,
  parameter int unsigned LOAD_BITS = 32,
  localparam int unsigned IdxW     = (PROCS > 1) ? $clog2(PROCS) : 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [IdxW-1:0]      rd_addr_i,
  output logic [LOAD_BITS-1:0] rd_data_o,
  input  logic                 wr_en_i,
  input  logic [IdxW-1:0]      wr_addr_i,
  input  logic [LOAD_BITS-1:0] wr_data_i,
  input  logic                 clr_i
);

  logic [LOAD_BITS-1:0] mem [PROCS];
  logic [PROCS-1:0]     valid_q;
  logic [LOAD_BITS-1:0] rd_data_q;

  // An entry that has not been written since the last clear reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (clr_i) begin
      valid_q <= '0;
    end else if (wr_en_i) begin
      valid_q[wr_addr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= valid_q[rd_addr_i] ? mem[rd_addr_i] : '0;
  end

  assign rd_data_o = rd_data_q;

endmodule

/* rtl/gms_scan_unit.sv */
module gms_scan_unit #(
  parameter int unsigned PROCS     = 16,
  parameter int unsigned LOAD_BITS = 32,
  localparam int unsigned IdxW     = (PROCS > 1) ? $clog2(PROCS) : 1
) (
  input  logic                      clk_i,
  input  gms_pkg::gms_scan_ctl_t    ctl_i,
  input  logic [IdxW-1:0]           idx_i,
  input  logic [LOAD_BITS-1:0]      load_i,
  input  logic [gms_pkg::WorkW-1:0] work_i,
  input  logic [LOAD_BITS-1:0]      largest_i,
  input  logic                      mode_i,
  output logic [IdxW-1:0]           pick_o,
  output logic [LOAD_BITS-1:0]      new_load_o
);

  import gms_pkg::*;

  logic [LOAD_BITS-1:0] min_q, bf_val_q;
  logic [IdxW-1:0]      min_idx_q, bf_idx_q;
  logic                 found_q;

  logic [LOAD_BITS-1:0] add_a;
  logic [LOAD_BITS:0]   sum;
  logic [LOAD_BITS-1:0] sum_sat;
  logic                 use_bf;

  // The one saturating adder serves the candidate loads during the scan and
  // the least load in the final step.
  assign add_a   = ctl_i.fin ? min_q : load_i;
  assign sum     = {1'b0, add_a} + (LOAD_BITS + 1)'(work_i);
  assign sum_sat = sum[LOAD_BITS] ? '1 : sum[LOAD_BITS-1:0];

  always_ff @(posedge clk_i) begin
    if (ctl_i.clear) begin
      bf_val_q <= '0;
      found_q  <= 1'b0;
    end else if (ctl_i.take) begin
      if ((idx_i == '0) || (load_i < min_q)) begin
        min_q     <= load_i;
        min_idx_q <= idx_i;
      end
      if ((sum_sat <= largest_i) && (sum_sat > bf_val_q)) begin
        bf_val_q <= sum_sat;
        bf_idx_q <= idx_i;
        found_q  <= 1'b1;
      end
    end
  end

  assign use_bf     = (mode_i == PolicyBest) && found_q;
  assign pick_o     = use_bf ? bf_idx_q : min_idx_q;
  assign new_load_o = use_bf ? bf_val_q : sum_sat;

endmodule

/* rtl/greedy_makespan_scheduler.sv */
// Greedy makespan scheduler. Each accepted task is placed on one of the
// active processors and its workload is added, saturating, to that
// processor's running load; the result transfer reports the chosen
// processor, the makespan so far (largest load, clipped to 32 bits) and
// whether the task closed a job. With policy_mode 0 the least loaded
// processor wins (lowest index on a tie); with policy_mode 1 the first
// processor whose new load would be the largest positive value not above
// the current makespan wins, falling back to least loaded when none fits.
// After a task marked last_task, all loads and the makespan return to zero.
// num_procs of zero acts as one and values above PROCS act as PROCS.
// The loads of the n active processors sit in a single-read-port memory
// that is scanned one word per cycle through one shared saturating adder;
// an update step then writes back the chosen load, updates the makespan
// and registers the result, waiting while the output register still holds
// a result that has not been taken.
// The input is not ready during the scan and the update step; a finished result
// waits in the output register while the next task is already taken. Configuration
// writes are always accepted and must only be issued while the block is idle.
module greedy_makespan_scheduler #(
  parameter int unsigned PROCS     = 16,
  parameter int unsigned LOAD_BITS = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  gms_pkg::gms_in_t                    in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output gms_pkg::gms_out_t                   out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [gms_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [gms_pkg::CfgDataW-1:0]        cfg_data_i
);

  import gms_pkg::*;

  localparam int unsigned IdxW = (PROCS > 1) ? $clog2(PROCS) : 1;
  localparam int unsigned CntW = $clog2(PROCS + 1);

  // Configuration registers.
  logic [4:0] num_procs_q;
  logic       policy_mode_q;

  // Sequencer state and per-task context.
  gms_state_e           state_q, state_d;
  logic [CntW-1:0]      n_q, n_d;
  logic [CntW-1:0]      iss_q, iss_d;
  logic                 rd_vld_q, rd_vld_d;
  logic [IdxW-1:0]      rd_idx_q;
  logic [WorkW-1:0]     work_q;
  logic                 last_q;
  logic                 mode_q;
  logic [LOAD_BITS-1:0] largest_q, largest_d;

  // Output register.
  logic                 out_vld_q, out_vld_d;
  gms_out_t             out_q, out_d;

  logic                 in_fire, upd_fire;
  logic [7:0]           np_wide;
  logic [CntW-1:0]      n_active;
  gms_scan_ctl_t        scan_ctl;
  logic [LOAD_BITS-1:0] ram_rd_data;
  logic [IdxW-1:0]      pick;
  logic [LOAD_BITS-1:0] new_load;
  logic [LOAD_BITS-1:0] new_largest;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_procs_q   <= 5'd1;
      policy_mode_q <= PolicyLeast;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegNumProcs:   num_procs_q   <= cfg_data_i[4:0];
        RegPolicyMode: policy_mode_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Clamp the programmed processor count to the built range.
  assign np_wide = 8'(num_procs_q);
  always_comb begin
    if (np_wide == 8'd0) begin
      n_active = CntW'(1);
    end else if (np_wide > 8'(PROCS)) begin
      n_active = CntW'(PROCS);
    end else begin
      n_active = CntW'(np_wide);
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign upd_fire   = (state_q == ST_UPDATE) && (!out_vld_q || out_ready_i);

  // Sequencer: issue one load read per cycle, then write back the winner.
  always_comb begin
    state_d   = state_q;
    n_d       = n_q;
    iss_d     = iss_q;
    rd_vld_d  = 1'b0;
    largest_d = largest_q;
    out_vld_d = out_vld_q && !out_ready_i;
    out_d     = out_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          n_d     = n_active;
          iss_d   = '0;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (iss_q < n_q) begin
          rd_vld_d = 1'b1;
          iss_d    = iss_q + CntW'(1);
        end else begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (upd_fire) begin
          largest_d         = last_q ? '0 : new_largest;
          out_vld_d         = 1'b1;
          out_d.chosen_proc = 4'(pick);
          out_d.makespan    = ((new_largest >> SpanW) != '0) ? '1 : SpanW'(new_largest);
          out_d.job_done    = last_q;
          state_d           = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      n_q       <= '0;
      iss_q     <= '0;
      rd_vld_q  <= 1'b0;
      largest_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      n_q       <= n_d;
      iss_q     <= iss_d;
      rd_vld_q  <= rd_vld_d;
      largest_q <= largest_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q    <= out_d;
    rd_idx_q <= iss_q[IdxW-1:0];
    if (in_fire) begin
      work_q <= in_data_i.task_work;
      last_q <= in_data_i.last_task;
      mode_q <= policy_mode_q;
    end
  end

  assign new_largest = (new_load > largest_q) ? new_load : largest_q;

  assign scan_ctl.clear = in_fire;
  assign scan_ctl.take  = rd_vld_q;
  assign scan_ctl.fin   = (state_q == ST_UPDATE);

  gms_load_ram #(
    .PROCS     (PROCS),
    .LOAD_BITS (LOAD_BITS)
  ) u_load_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (iss_q[IdxW-1:0]),
    .rd_data_o (ram_rd_data),
    .wr_en_i   (upd_fire && !last_q),
    .wr_addr_i (pick),
    .wr_data_i (new_load),
    .clr_i     (upd_fire && last_q)
  );

  gms_scan_unit #(
    .PROCS     (PROCS),
    .LOAD_BITS (LOAD_BITS)
  ) u_scan_unit (
    .clk_i      (clk_i),
    .ctl_i      (scan_ctl),
    .idx_i      (rd_idx_q),
    .load_i     (ram_rd_data),
    .work_i     (work_q),
    .largest_i  (largest_q),
    .mode_i     (mode_q),
    .pick_o     (pick),
    .new_load_o (new_load)
  );

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // A task transfer always starts a scan, so the input drops ready right after.
  a_busy_after_task: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o)
    else $error("input still ready after a task transfer");

  // The chosen processor lies inside the active range.
  a_pick_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPDATE) |-> (CntW'(pick) < n_q))
    else $error("chosen processor outside the active range");

  // After a write-back the makespan covers the load that was written.
  a_largest_covers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upd_fire && !last_q) |=> (largest_q >= $past(new_load)))
    else $error("makespan below an updated load");

  // A job close leaves the makespan at zero.
  a_job_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upd_fire && last_q) |=> (largest_q == '0))
    else $error("makespan not cleared at end of job");

endmodule

/* test/tb_top.sv */
module tb_top;
  import gms_pkg::*;

  // Checks each result transfer against a private copy of the scheduler state.
  class placement_scoreboard #(int unsigned PROCS = 16, int unsigned LOAD_BITS = 32);
    typedef bit [LOAD_BITS-1:0] load_t;

    load_t       load[PROCS];
    load_t       peak;
    bit [4:0]    procs_reg;
    bit          policy_reg;
    gms_out_t    placements_due[$];
    int unsigned mismatches;

    function new();
      foreach (load[i]) load[i] = '0;
      peak       = '0;
      procs_reg  = 5'd1;
      policy_reg = PolicyLeast;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      if (idx == RegNumProcs) begin
        procs_reg = data[4:0];
      end else if (idx == RegPolicyMode) begin
        policy_reg = data[0];
      end
    endfunction

    // Saturating add of a workload onto a processor load.
    function load_t grow(load_t base, bit [WorkW-1:0] work);
      bit [LOAD_BITS:0] sum;
      sum = base + work;
      return sum[LOAD_BITS] ? '1 : sum[LOAD_BITS-1:0];
    endfunction

    function int unsigned lightest(int unsigned n);
      int unsigned best;
      best = 0;
      for (int unsigned i = 1; i < n; i++) begin
        if (load[i] < load[best]) best = i;
      end
      return best;
    endfunction

    // Places one accepted task and queues the result it must produce.
    function void note_task(gms_in_t t);
      int unsigned n;
      int unsigned pick;
      load_t       cand;
      load_t       top;
      bit          found;
      bit [63:0]   wide;
      gms_out_t    due;
      n     = (procs_reg == 0) ? 1 : ((procs_reg > PROCS) ? PROCS : procs_reg);
      found = 1'b0;
      top   = '0;
      pick  = 0;
      if (policy_reg == PolicyBest) begin
        for (int unsigned i = 0; i < n; i++) begin
          cand = grow(load[i], t.task_work);
          if (cand <= peak && cand > top) begin
            top   = cand;
            pick  = i;
            found = 1'b1;
          end
        end
      end
      if (!found) pick = lightest(n);
      load[pick] = grow(load[pick], t.task_work);
      if (load[pick] > peak) peak = load[pick];
      wide            = 64'(peak);
      due.chosen_proc = pick[3:0];
      due.makespan    = (wide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : wide[31:0];
      due.job_done    = t.last_task;
      placements_due.push_back(due);
      if (t.last_task) begin
        foreach (load[i]) load[i] = '0;
        peak = '0;
      end
    endfunction

    function void check_placement(gms_out_t got);
      gms_out_t due;
      if (placements_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result: proc %0d span %0d done %0b",
                   got.chosen_proc, got.makespan, got.job_done);
        end
      end else begin
        due = placements_due.pop_front();
        if (got.chosen_proc != due.chosen_proc || got.makespan != due.makespan ||
            got.job_done != due.job_done) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display({"mismatch: expected proc %0d span %0d done %0b, ",
                      "got proc %0d span %0d done %0b"},
                     due.chosen_proc, due.makespan, due.job_done,
                     got.chosen_proc, got.makespan, got.job_done);
          end
        end
      end
    endfunction

    function int unsigned pending();
      return placements_due.size();
    endfunction
  endclass

  localparam int unsigned PROCS     = 16;
  localparam int unsigned LOAD_BITS = 32;
  // Settling time: a full scan of PROCS loads and its update step, plus margin.
  localparam int unsigned SETTLE    = PROCS + 8;
  // The limit lies well above the slowest correct run: about 2300 tasks
  // under the longest idle and stall bursts, plus settling between phases.
  localparam int unsigned LIMIT     = 1_000_000;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  gms_in_t             in_data_i;
  logic                out_valid_o;
  logic                out_ready_i;
  gms_out_t            out_data_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  placement_scoreboard #(PROCS, LOAD_BITS) sb;

  // When set, both sides insert random idle bursts; cleared for the last
  // part of the run so the block also sees back-to-back traffic.
  bit          pace_on;
  int unsigned cycles;

  greedy_makespan_scheduler #(
    .PROCS     (PROCS),
    .LOAD_BITS (LOAD_BITS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("FAIL greedy_makespan_scheduler");
      $finish;
    end
  end

  // Result monitor. Signals read here hold their values from before the
  // edge, so a transfer is seen exactly when valid and ready were both high.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_placement(out_data_o);
  end

  // Result side back-pressure: mostly ready, with random stall bursts
  // while pacing is enabled.
  initial begin
    out_ready_i <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (pace_on && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk_i);
    end
  end

  // Offers one task and returns at the edge where it is transferred, with
  // valid still high so the next task can follow without a bubble.
  task automatic send_task(bit [WorkW-1:0] work, bit last);
    gms_in_t item;
    item.task_work = work;
    item.last_task = last;
    if (pace_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_task(item);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Stops offering tasks, waits for every outstanding result, then lets the
  // block finish any write-back before registers may be touched.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Workloads lean towards sizes comparable to the running loads so that
  // the best-fit search finds real candidates, with the extremes mixed in.
  function automatic bit [WorkW-1:0] pick_work();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return WorkW'($urandom_range(1, 300));
      5, 6:    return WorkW'($urandom_range(0, 65535));
      default: return WorkW'($urandom_range(1000, 5000));
    endcase
  endfunction

  // New register settings for a phase. Now and then only one register is
  // written, and phases may start inside an open job, which covers a
  // processor count changed mid-job.
  task automatic shuffle_config();
    logic [CfgDataW-1:0] procs_word;
    logic [CfgDataW-1:0] policy_word;
    int unsigned         how;
    procs_word  = ($urandom_range(0, 1) == 0) ? '0 : CfgDataW'($urandom);
    policy_word = ($urandom_range(0, 1) == 0) ? '0 : CfgDataW'($urandom);
    case ($urandom_range(0, 9))
      0:       procs_word[4:0] = 5'd0;
      1:       procs_word[4:0] = 5'($urandom_range(17, 31));
      2:       procs_word[4:0] = 5'd16;
      3:       procs_word[4:0] = 5'd1;
      default: procs_word[4:0] = 5'($urandom_range(1, 16));
    endcase
    policy_word[0] = ($urandom_range(0, 1) == 0) ? PolicyLeast : PolicyBest;
    how = $urandom_range(0, 5);
    if (how == 0) begin
      write_reg(RegNumProcs, procs_word);
    end else if (how == 1) begin
      write_reg(RegPolicyMode, policy_word);
    end else if (how == 2) begin
      write_reg(RegPolicyMode, policy_word);
      write_reg(RegNumProcs, procs_word);
    end else begin
      write_reg(RegNumProcs, procs_word);
      write_reg(RegPolicyMode, policy_word);
    end
  endtask

  // Mostly whole jobs of random length closed by a last task; the rest are
  // lone tasks with a random last flag and jobs left open.
  task automatic run_jobs(int unsigned count);
    int unsigned sent;
    int unsigned len;
    bit          keep_open;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 9) == 0) begin
        send_task(pick_work(), 1'($urandom_range(0, 1)));
        sent++;
      end else begin
        len       = $urandom_range(1, 24);
        keep_open = ($urandom_range(0, 7) == 0);
        for (int unsigned i = 0; i < len; i++) begin
          send_task(pick_work(), (i == len - 1) && !keep_open);
        end
        sent += len;
      end
    end
  endtask

  initial begin
    sb          = new();
    pace_on     = 1'b1;
    cycles      = 0;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i  <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A processor count of zero behaves as one processor.
    write_reg(RegNumProcs, 32'd0);
    write_reg(RegPolicyMode, 32'(PolicyLeast));
    send_task(16'h0000, 1'b0);
    send_task(16'hFFFF, 1'b1);
    settle();

    // A count above the built size is clipped. In best-fit mode the first
    // task, with zero load everywhere, finds no candidate and falls back;
    // a zero workload on an empty processor never qualifies as a candidate.
    write_reg(RegNumProcs, 32'd31);
    write_reg(RegPolicyMode, 32'(PolicyBest));
    send_task(16'h0000, 1'b0);
    send_task(16'hFFFF, 1'b0);
    send_task(16'h5555, 1'b0);
    send_task(16'hAAAA, 1'b0);
    send_task(16'h0001, 1'b0);
    send_task(16'h7FFF, 1'b0);
    send_task(16'h8000, 1'b1);
    settle();

    // Least-loaded over all processors, leaving the job open. Shrinking the
    // count afterwards keeps the outer loads in the makespan.
    write_reg(RegNumProcs, 32'd16);
    write_reg(RegPolicyMode, 32'(PolicyLeast));
    send_task(16'h1234, 1'b0);
    send_task(16'h00FF, 1'b0);
    send_task(16'hFF00, 1'b0);
    send_task(16'h0F0F, 1'b0);
    send_task(16'hF0F0, 1'b0);
    send_task(16'h0000, 1'b0);
    settle();
    write_reg(RegNumProcs, 32'd3);
    write_reg(RegPolicyMode, 32'(PolicyBest));
    send_task(16'h0100, 1'b0);
    send_task(16'h0200, 1'b0);
    send_task(16'h0000, 1'b0);
    send_task(16'h0300, 1'b1);
    settle();

    // Best-fit with a single processor.
    write_reg(RegNumProcs, 32'd1);
    send_task(16'h0010, 1'b0);
    send_task(16'hFFFF, 1'b0);
    send_task(16'h0001, 1'b1);
    settle();

    // Random phases; some of them run without pacing so that unbroken
    // streams appear early as well.
    for (int unsigned phase = 0; phase < 20; phase++) begin
      pace_on = (phase >= 18) ? 1'b0 : ($urandom_range(0, 3) != 0);
      shuffle_config();
      run_jobs(100);
      settle();
    end

    // One processor takes a run of full-size tasks so that its load grows
    // far beyond the workload range.
    pace_on = 1'b0;
    write_reg(RegNumProcs, 32'd1);
    write_reg(RegPolicyMode, 32'(PolicyLeast));
    for (int unsigned i = 0; i < 100; i++) send_task(16'hFFFF, 1'b0);
    settle();

    // Best-fit next to a heavily loaded processor: the idle one is the only
    // candidate that stays within the makespan.
    write_reg(RegNumProcs, 32'd2);
    write_reg(RegPolicyMode, 32'(PolicyBest));
    send_task(16'hFFFF, 1'b0);
    send_task(16'h0000, 1'b0);
    send_task(16'h0005, 1'b1);
    settle();

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASS greedy_makespan_scheduler");
    end else begin
      $display("FAIL greedy_makespan_scheduler");
    end
    $finish;
  end
endmodule

/* greedy_makespan_scheduler.f */
rtl/gms_pkg.sv
rtl/gms_load_ram.sv
rtl/gms_scan_unit.sv
rtl/greedy_makespan_scheduler.sv
test/tb_top.sv
